### src/terminal_escape_input_decoder_unit_assert.svh
// assertion macros shared by the decoder modules
// expects clk and arst_n in the scope of each use
`ifndef TERMINAL_ESCAPE_INPUT_DECODER_UNIT_ASSERT_SVH
`define TERMINAL_ESCAPE_INPUT_DECODER_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define TEID_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define TEID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/teid_pkg.sv
// shared types and constants for the escape sequence input decoder
// no dependencies
`default_nettype none

package teid_pkg;

	localparam int unsigned DEFAULT_COORD_MAX = 4095;
	localparam int unsigned QUEUE_DEPTH       = 2;
	localparam int unsigned HEAD_LEN          = 5;

	// byte values
	localparam logic [7:0] CHAR_NUL    = 8'h00;
	localparam logic [7:0] CHAR_ESC    = 8'h1B;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_SEMI   = 8'h3B;
	localparam logic [7:0] CHAR_LT     = 8'h3C;
	localparam logic [7:0] CHAR_LBRACK = 8'h5B;
	localparam logic [7:0] CHAR_TILDE  = 8'h7E;
	localparam logic [7:0] CHAR_SS3    = 8'h4F;
	localparam logic [7:0] CHAR_M      = 8'h4D;

	// mouse parser phases
	localparam logic [3:0] PH_LBRACK = 4'd0;
	localparam logic [3:0] PH_LESS   = 4'd1;
	localparam logic [3:0] PH_NUM0   = 4'd2;
	localparam logic [3:0] PH_LAST   = 4'd7;
	localparam logic [3:0] PH_DONE   = 4'd8;

	// key codes
	localparam logic [4:0] KEY_NONE  = 5'd0;
	localparam logic [4:0] KEY_CHAR  = 5'd1;
	localparam logic [4:0] KEY_F1    = 5'd2;
	localparam logic [4:0] KEY_F2    = 5'd3;
	localparam logic [4:0] KEY_F3    = 5'd4;
	localparam logic [4:0] KEY_F4    = 5'd5;
	localparam logic [4:0] KEY_F5    = 5'd6;
	localparam logic [4:0] KEY_F6    = 5'd7;
	localparam logic [4:0] KEY_F7    = 5'd8;
	localparam logic [4:0] KEY_F8    = 5'd9;
	localparam logic [4:0] KEY_F9    = 5'd10;
	localparam logic [4:0] KEY_F10   = 5'd11;
	localparam logic [4:0] KEY_F11   = 5'd12;
	localparam logic [4:0] KEY_F12   = 5'd13;
	localparam logic [4:0] KEY_UP    = 5'd14;
	localparam logic [4:0] KEY_DOWN  = 5'd15;
	localparam logic [4:0] KEY_RIGHT = 5'd16;
	localparam logic [4:0] KEY_LEFT  = 5'd17;
	localparam logic [4:0] KEY_HOME  = 5'd18;
	localparam logic [4:0] KEY_END   = 5'd19;
	localparam logic [4:0] KEY_INS   = 5'd20;
	localparam logic [4:0] KEY_DEL   = 5'd21;
	localparam logic [4:0] KEY_PGUP  = 5'd22;
	localparam logic [4:0] KEY_PGDN  = 5'd23;

	// mouse events
	localparam logic [2:0] EV_NONE   = 3'd0;
	localparam logic [2:0] EV_LEFT   = 3'd1;
	localparam logic [2:0] EV_SCR_UP = 3'd4;
	localparam logic [2:0] EV_SCR_DN = 3'd5;
	localparam logic [2:0] EV_MOVED  = 3'd6;

	// one finished sequence, as handed from front to back
	typedef struct packed {
		logic [7:0]  c1;
		logic [7:0]  c2;
		logic [7:0]  c3;
		logic [7:0]  c4;
		logic [7:0]  c5;
		logic        fin_m;
		logic [6:0]  type_lo;
		logic        type_hi;
		logic [12:0] x;
		logic [12:0] y;
	} snap_t;

endpackage

`default_nettype wire

### src/teid_front.sv
// front end: takes sequence bytes, keeps the head bytes and runs the mouse number parser
// depends on teid_pkg and the assertion macro header
`default_nettype none
`include "terminal_escape_input_decoder_unit_assert.svh"

module teid_front #(
	parameter int unsigned COORD_MAX = teid_pkg::DEFAULT_COORD_MAX
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     seq_byte,
	input  wire logic           seq_end,
	input  wire logic           full,
	output logic                push,
	output teid_pkg::snap_t     push_snap
);
	import teid_pkg::*;

	localparam int unsigned NW = $clog2(COORD_MAX + 1);
	localparam int unsigned AW = NW + 4;

	logic [7:0]    head_q [0:HEAD_LEN-1];
	logic [2:0]    cnt_q;
	logic          stop_q;
	logic [3:0]    phase_q;
	logic [NW-1:0] num_q [0:2];
	logic [7:0]    fin_q;

	logic [7:0]    head_nx [0:HEAD_LEN-1];
	logic [2:0]    cnt_nx;
	logic          stop_nx;
	logic [3:0]    phase_nx;
	logic [NW-1:0] num_nx [0:2];
	logic [7:0]    fin_nx;

	logic          fire;
	logic          term;
	logic          take;
	logic          is_dig;
	logic [7:0]    diff;
	logic [3:0]    ph_off;
	logic [1:0]    k;
	logic [NW-1:0] cur;
	logic [AW-1:0] acc;
	logic [NW-1:0] sat;

	assign in_ready = !full;
	assign fire     = in_valid && in_ready;
	assign term     = (seq_byte == CHAR_ESC) || (seq_byte == CHAR_NUL);
	assign take     = fire && !stop_q && !term;
	assign is_dig   = (seq_byte >= CHAR_ZERO) && (seq_byte <= CHAR_NINE);
	assign diff     = seq_byte - CHAR_ZERO;
	assign ph_off   = phase_q - PH_NUM0;
	assign k        = ph_off[2:1];

	always_comb begin
		unique case (k)
			2'd0:    cur = num_q[0];
			2'd1:    cur = num_q[1];
			default: cur = num_q[2];
		endcase
	end

	// times ten plus digit, then clamp
	assign acc = ({4'b0, cur} << 3) + ({4'b0, cur} << 1) + AW'(diff[3:0]);
	assign sat = (acc > AW'(COORD_MAX)) ? NW'(COORD_MAX) : acc[NW-1:0];

	always_comb begin
		for (int i = 0; i < HEAD_LEN; i++) begin
			head_nx[i] = head_q[i];
		end
		for (int i = 0; i < 3; i++) begin
			num_nx[i] = num_q[i];
		end
		cnt_nx   = cnt_q;
		stop_nx  = stop_q || (fire && term);
		phase_nx = phase_q;
		fin_nx   = fin_q;
		if (take) begin
			if (cnt_q < 3'(HEAD_LEN)) begin
				for (int i = 0; i < HEAD_LEN; i++) begin
					if (cnt_q == 3'(i)) begin
						head_nx[i] = seq_byte;
					end
				end
				cnt_nx = cnt_q + 3'd1;
			end
			priority if (phase_q == PH_LBRACK) begin
				phase_nx = (seq_byte == CHAR_LBRACK) ? PH_LESS : PH_DONE;
			end else if (phase_q == PH_LESS) begin
				phase_nx = (seq_byte == CHAR_LT) ? PH_NUM0 : PH_DONE;
			end else if (phase_q >= PH_NUM0 && phase_q <= PH_LAST) begin
				if (is_dig) begin
					for (int i = 0; i < 3; i++) begin
						if (k == 2'(i)) begin
							num_nx[i] = sat;
						end
					end
					phase_nx = PH_NUM0 + {1'b0, k, 1'b1};
				end else if (!phase_q[0]) begin
					// a number must start with a digit
					phase_nx = PH_DONE;
				end else if (k < 2'd2) begin
					phase_nx = (seq_byte == CHAR_SEMI) ? (PH_NUM0 + {1'b0, k + 2'd1, 1'b0})
						: PH_DONE;
				end else begin
					fin_nx   = seq_byte;
					phase_nx = PH_DONE;
				end
			end else begin
				phase_nx = phase_q;
			end
		end
	end

	assign push = fire && seq_end;

	always_comb begin
		push_snap.c1      = head_nx[0];
		push_snap.c2      = head_nx[1];
		push_snap.c3      = head_nx[2];
		push_snap.c4      = head_nx[3];
		push_snap.c5      = head_nx[4];
		push_snap.fin_m   = (fin_nx == CHAR_M);
		push_snap.type_lo = num_nx[0][6:0];
		push_snap.type_hi = |num_nx[0][NW-1:7];
		push_snap.x       = 13'(num_nx[1]);
		push_snap.y       = 13'(num_nx[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HEAD_LEN; i++) begin
				head_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				num_q[i] <= '0;
			end
			cnt_q   <= '0;
			stop_q  <= 1'b0;
			phase_q <= PH_LBRACK;
			fin_q   <= '0;
		end else if (push) begin
			// sequence handed on, start afresh
			for (int i = 0; i < HEAD_LEN; i++) begin
				head_q[i] <= '0;
			end
			for (int i = 0; i < 3; i++) begin
				num_q[i] <= '0;
			end
			cnt_q   <= '0;
			stop_q  <= 1'b0;
			phase_q <= PH_LBRACK;
			fin_q   <= '0;
		end else if (fire) begin
			for (int i = 0; i < HEAD_LEN; i++) begin
				head_q[i] <= head_nx[i];
			end
			for (int i = 0; i < 3; i++) begin
				num_q[i] <= num_nx[i];
			end
			cnt_q   <= cnt_nx;
			stop_q  <= stop_nx;
			phase_q <= phase_nx;
			fin_q   <= fin_nx;
		end
	end

	`TEID_ASSERT_NEXT(a_front_clear, push,
		(cnt_q == 3'd0) && !stop_q && (phase_q == PH_LBRACK), "front state not cleared")

endmodule

`default_nettype wire

### src/teid_queue.sv
// short queue of finished sequences between front and back
// depends on teid_pkg and the assertion macro header
`default_nettype none
`include "terminal_escape_input_decoder_unit_assert.svh"

module teid_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire teid_pkg::snap_t push_snap,
	output logic                 full,
	output logic                 head_valid,
	output teid_pkg::snap_t      head_snap,
	input  wire logic            pop
);
	import teid_pkg::*;

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	snap_t         slot_q [0:QUEUE_DEPTH-1];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_snap  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_snap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`TEID_ASSERT_NOW(a_queue_no_overrun, push, !full, "push into full queue")
	`TEID_ASSERT_NOW(a_queue_no_underrun, pop, head_valid, "pop from empty queue")

endmodule

`default_nettype wire

### src/teid_back.sv
// back end: decodes a finished sequence into key or mouse fields and holds the result
// depends on teid_pkg and the assertion macro header
`default_nettype none
`include "terminal_escape_input_decoder_unit_assert.svh"

module teid_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire teid_pkg::snap_t head_snap,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [4:0]           key_code,
	output logic [7:0]           key_char,
	output logic                 shift_mod,
	output logic                 ctrl_mod,
	output logic                 alt_mod,
	output logic                 mouse_valid,
	output logic                 mouse_pressed,
	output logic [2:0]           mouse_event,
	output logic signed [12:0]   mouse_col,
	output logic signed [12:0]   mouse_row
);
	import teid_pkg::*;

	logic [7:0]  c1, c2, c3, c4, c5, c2e;
	logic [7:0]  r8;
	logic        is_mouse;
	logic        mod_blk;
	logic        found;
	logic [2:0]  m;
	logic [4:0]  key_d;
	logic [7:0]  kch_d;
	logic        sh_d, ct_d, al_d, mp_d;
	logic [2:0]  mev_d;
	logic [12:0] col_d, row_d;

	logic        out_valid_q;
	logic [4:0]  key_q;
	logic [7:0]  kch_q;
	logic        sh_q, ct_q, al_q, mv_q, mp_q;
	logic [2:0]  mev_q;
	logic [12:0] col_q, row_q;

	assign c1 = head_snap.c1;
	assign c2 = head_snap.c2;
	assign c3 = head_snap.c3;
	assign c4 = head_snap.c4;
	assign c5 = head_snap.c5;

	assign is_mouse = (c1 == CHAR_LBRACK) && (c2 == CHAR_LT);
	// type with the alt and ctrl bits masked, top bit stands for anything above 127
	assign r8 = {head_snap.type_hi, head_snap.type_lo & 7'b1100111};

	assign mod_blk = ((c2 == 8'h31) && (c3 == CHAR_SEMI))
		|| (((c2 == 8'h32) || (c2 == 8'h31)) && (c4 == CHAR_SEMI))
		|| ((c2 >= 8'h32) && (c2 <= 8'h38));
	// "1;" form takes the key letter from the fifth byte
	assign c2e = ((c2 == 8'h31) && (c3 == CHAR_SEMI)) ? c5 : c2;

	always_comb begin
		found = 1'b0;
		m     = 3'd0;
		for (int d = 2; d <= 8; d++) begin
			if (!found && ((c4 == 8'(48 + d)) || (c5 == 8'(48 + d)))) begin
				found = 1'b1;
				m     = 3'(d - 1);
			end
		end
	end

	always_comb begin
		key_d = KEY_NONE;
		kch_d = 8'h00;
		sh_d  = 1'b0;
		ct_d  = 1'b0;
		al_d  = 1'b0;
		mp_d  = 1'b0;
		mev_d = EV_NONE;
		col_d = '1;
		row_d = '1;

		if (is_mouse) begin
			mp_d = head_snap.fin_m;
			priority if ((r8 <= 8'd2) || ((r8 >= 8'd32) && (r8 <= 8'd34))) begin
				mev_d = EV_LEFT + {1'b0, r8[1:0]};
			end else if (r8 == 8'd35) begin
				mev_d = EV_MOVED;
			end else if (r8 == 8'd64) begin
				mev_d = EV_SCR_UP;
			end else if (r8 == 8'd65) begin
				mev_d = EV_SCR_DN;
			end else begin
				mev_d = EV_NONE;
			end
			if (mev_d != EV_NONE) begin
				al_d = head_snap.type_lo[3];
				ct_d = head_snap.type_lo[4];
			end
			col_d = head_snap.x - 13'd1;
			row_d = head_snap.y - 13'd1;
		end

		if (c1 == CHAR_LBRACK) begin
			if (mod_blk && found) begin
				sh_d = sh_d | m[0];
				al_d = al_d | m[1];
				ct_d = ct_d | m[2];
			end
			priority if (c2e == 8'h31) begin
				unique case (c3)
					8'h35:   key_d = KEY_F5;
					8'h37:   key_d = KEY_F6;
					8'h38:   key_d = KEY_F7;
					8'h39:   key_d = KEY_F8;
					default: key_d = KEY_NONE;
				endcase
			end else if (c2e == 8'h32) begin
				unique case (c3)
					8'h30:   key_d = KEY_F9;
					8'h31:   key_d = KEY_F10;
					8'h33:   key_d = KEY_F11;
					8'h34:   key_d = KEY_F12;
					default: key_d = KEY_NONE;
				endcase
			end else begin
				unique case (c2e)
					8'h41:   key_d = KEY_UP;
					8'h42:   key_d = KEY_DOWN;
					8'h43:   key_d = KEY_RIGHT;
					8'h44:   key_d = KEY_LEFT;
					8'h48:   key_d = KEY_HOME;
					8'h46:   key_d = KEY_END;
					default: key_d = KEY_NONE;
				endcase
			end
			if ((c3 == CHAR_TILDE) || (c3 == CHAR_SEMI)) begin
				unique case (c2e)
					8'h32:   key_d = KEY_INS;
					8'h33:   key_d = KEY_DEL;
					8'h35:   key_d = KEY_PGUP;
					8'h36:   key_d = KEY_PGDN;
					default: key_d = key_d;
				endcase
			end
		end else if (c1 == CHAR_SS3) begin
			unique case (c2)
				8'h50:   key_d = KEY_F1;
				8'h51:   key_d = KEY_F2;
				8'h52:   key_d = KEY_F3;
				8'h53:   key_d = KEY_F4;
				default: key_d = KEY_NONE;
			endcase
		end else begin
			key_d = KEY_CHAR;
			kch_d = c1;
			al_d  = 1'b1;
		end
	end

	assign pop = head_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			key_q <= key_d;
			kch_q <= kch_d;
			sh_q  <= sh_d;
			ct_q  <= ct_d;
			al_q  <= al_d;
			mv_q  <= is_mouse;
			mp_q  <= mp_d;
			mev_q <= mev_d;
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign key_code      = key_q;
	assign key_char      = kch_q;
	assign shift_mod     = sh_q;
	assign ctrl_mod      = ct_q;
	assign alt_mod       = al_q;
	assign mouse_valid   = mv_q;
	assign mouse_pressed = mp_q;
	assign mouse_event   = mev_q;
	assign mouse_col     = col_q;
	assign mouse_row     = row_q;

	`TEID_ASSERT_NOW(a_back_load_only_on_pop, $rose(out_valid_q), $past(pop),
		"result appeared without a pop")
	`TEID_ASSERT_NOW(a_back_no_overwrite, pop, !out_valid_q || out_ready,
		"held result overwritten")

endmodule

`default_nettype wire

### src/terminal_escape_input_decoder_unit.sv
// path: a finished sequence is written into the queue, then decoded from the queue head and registered at the output
// throughput: one item per cycle; the front stalls only when the two-entry queue is full
// results leave at up to one per cycle through the registered output stage
// reset: asynchronous, clears the parser state, queue pointers and output valid
// depends on teid_pkg, teid_front, teid_queue and teid_back
`default_nettype none

module terminal_escape_input_decoder_unit #(
	parameter int unsigned COORD_MAX = teid_pkg::DEFAULT_COORD_MAX
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   seq_byte,
	input  wire logic         seq_end,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [4:0]        key_code,
	output logic [7:0]        key_char,
	output logic              shift_mod,
	output logic              ctrl_mod,
	output logic              alt_mod,
	output logic              mouse_valid,
	output logic              mouse_pressed,
	output logic [2:0]        mouse_event,
	output logic signed [12:0] mouse_col,
	output logic signed [12:0] mouse_row
);
	import teid_pkg::*;

	logic  full;
	logic  push;
	snap_t push_snap;
	logic  head_valid;
	snap_t head_snap;
	logic  pop;

	teid_front #(
		.COORD_MAX(COORD_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.seq_byte  (seq_byte),
		.seq_end   (seq_end),
		.full      (full),
		.push      (push),
		.push_snap (push_snap)
	);

	teid_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_snap  (push_snap),
		.full       (full),
		.head_valid (head_valid),
		.head_snap  (head_snap),
		.pop        (pop)
	);

	teid_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_snap     (head_snap),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.key_code      (key_code),
		.key_char      (key_char),
		.shift_mod     (shift_mod),
		.ctrl_mod      (ctrl_mod),
		.alt_mod       (alt_mod),
		.mouse_valid   (mouse_valid),
		.mouse_pressed (mouse_pressed),
		.mouse_event   (mouse_event),
		.mouse_col     (mouse_col),
		.mouse_row     (mouse_row)
	);

endmodule

`default_nettype wire

### tb/tb_terminal_escape_input_decoder_unit.sv
// self-checking testbench for terminal_escape_input_decoder_unit: escape byte streams in,
// decoded key and mouse reports out, compared against a predictor kept in the bench
// depends on teid_pkg and the decoder rtl

module tb_terminal_escape_input_decoder_unit;
	import teid_pkg::*;

	// xterm sgr mouse type codes that need a name of their own
	localparam int unsigned MTYPE_BUTTON_MAX = 2;
	localparam int unsigned MTYPE_DRAG_LO    = 32;
	localparam int unsigned MTYPE_DRAG_HI    = 34;
	localparam int unsigned MTYPE_MOVE       = 35;
	localparam int unsigned MTYPE_WHEEL_UP   = 64;
	localparam int unsigned MTYPE_WHEEL_DN   = 65;
	localparam int unsigned MTYPE_MOD_MASK   = 32'h18;

	typedef struct packed {
		logic [4:0]  key;
		logic [7:0]  ch;
		logic        sh;
		logic        ct;
		logic        al;
		logic        mv;
		logic        mp;
		logic [2:0]  ev;
		logic [12:0] col;
		logic [12:0] row;
	} key_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] seq_byte = 8'd0;
	logic seq_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [4:0] key_code;
	logic [7:0] key_char;
	logic shift_mod, ctrl_mod, alt_mod;
	logic mouse_valid, mouse_pressed;
	logic [2:0] mouse_event;
	logic signed [12:0] mouse_col, mouse_row;

	terminal_escape_input_decoder_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.seq_byte(seq_byte), .seq_end(seq_end),
		.out_valid(out_valid), .out_ready(out_ready),
		.key_code(key_code), .key_char(key_char),
		.shift_mod(shift_mod), .ctrl_mod(ctrl_mod), .alt_mod(alt_mod),
		.mouse_valid(mouse_valid), .mouse_pressed(mouse_pressed),
		.mouse_event(mouse_event), .mouse_col(mouse_col), .mouse_row(mouse_row)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// decoder state as the bench sees it
	logic [7:0] head_q [HEAD_LEN];
	int unsigned kept;
	bit halted;
	logic [3:0] phase;
	int unsigned num [3];
	logic [7:0] fin_ch;

	key_report_t expected_reports [$];
	key_report_t head_report;
	logic [7:0] seq_bytes [$];

	int errors = 0;
	int live_items = 0;
	int sequences = 0;
	int mouse_seen = 0;
	int keys_seen = 0;
	int input_stalls = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_len = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	function automatic void clear_decoder();
		for (int i = 0; i < HEAD_LEN; i++) head_q[i] = 8'd0;
		kept = 0;
		halted = 1'b0;
		phase = PH_LBRACK;
		for (int i = 0; i < 3; i++) num[i] = 0;
		fin_ch = 8'd0;
	endfunction

	// sgr mouse parser: phases from PH_NUM0 hold number k, odd once a digit is seen
	function automatic void mouse_parse(input logic [7:0] b);
		logic dig;
		int unsigned k, v;
		dig = (b >= CHAR_ZERO && b <= CHAR_NINE);
		if (phase == PH_LBRACK) begin
			phase = (b == CHAR_LBRACK) ? PH_LESS : PH_DONE;
		end else if (phase == PH_LESS) begin
			phase = (b == CHAR_LT) ? PH_NUM0 : PH_DONE;
		end else if (phase >= PH_NUM0 && phase <= PH_LAST) begin
			k = (phase - PH_NUM0) >> 1;
			if (dig) begin
				v = num[k] * 10 + (b - CHAR_ZERO);
				num[k] = (v > DEFAULT_COORD_MAX) ? DEFAULT_COORD_MAX : v;
				phase = 4'(PH_NUM0 + 2 * k + 1);
			end else if (!phase[0]) begin
				phase = PH_DONE;
			end else if (k < 2) begin
				phase = (b == CHAR_SEMI) ? 4'(PH_NUM0 + 2 * (k + 1)) : PH_DONE;
			end else begin
				fin_ch = b;
				phase = PH_DONE;
			end
		end
	endfunction

	function automatic key_report_t decode_report();
		key_report_t r;
		logic [7:0] c1, c2, c3, c4, c5;
		int unsigned t, rt, m;
		bit found;
		r = '0;
		r.col = '1;
		r.row = '1;
		found = 1'b0;
		c1 = head_q[0];
		c2 = head_q[1];
		c3 = head_q[2];
		c4 = head_q[3];
		c5 = head_q[4];
		if (c1 == CHAR_LBRACK && c2 == CHAR_LT) begin
			t = num[0];
			rt = t & ~MTYPE_MOD_MASK;
			r.mv = 1'b1;
			r.mp = (fin_ch == CHAR_M);
			if (rt <= MTYPE_BUTTON_MAX || (rt >= MTYPE_DRAG_LO && rt <= MTYPE_DRAG_HI))
				r.ev = EV_LEFT + 3'(rt & 3);
			else if (rt == MTYPE_MOVE) r.ev = EV_MOVED;
			else if (rt == MTYPE_WHEEL_UP) r.ev = EV_SCR_UP;
			else if (rt == MTYPE_WHEEL_DN) r.ev = EV_SCR_DN;
			if (r.ev != EV_NONE) begin
				if (t[3]) r.al = 1'b1;
				if (t[4]) r.ct = 1'b1;
			end
			r.col = 13'(num[1] - 1);
			r.row = 13'(num[2] - 1);
		end
		if (c1 == CHAR_LBRACK) begin
			if ((c2 == "1" && c3 == CHAR_SEMI) || ((c2 == "2" || c2 == "1") && c4 == CHAR_SEMI) ||
			    (c2 >= "2" && c2 <= "8")) begin
				// "[1;m<letter>": the letter sits in the fifth byte
				if (c2 == "1" && c3 == CHAR_SEMI) c2 = c5;
				for (int d = 2; d <= 8 && !found; d++) begin
					if (c4 == CHAR_ZERO + d || c5 == CHAR_ZERO + d) begin
						m = d - 1;
						if (m & 1) r.sh = 1'b1;
						if (m & 2) r.al = 1'b1;
						if (m & 4) r.ct = 1'b1;
						found = 1'b1;
					end
				end
			end
			case (c2)
				"1": begin
					case (c3)
						"5": r.key = KEY_F5;
						"7": r.key = KEY_F6;
						"8": r.key = KEY_F7;
						"9": r.key = KEY_F8;
						default: ;
					endcase
				end
				"2": begin
					case (c3)
						"0": r.key = KEY_F9;
						"1": r.key = KEY_F10;
						"3": r.key = KEY_F11;
						"4": r.key = KEY_F12;
						default: ;
					endcase
				end
				"A": r.key = KEY_UP;
				"B": r.key = KEY_DOWN;
				"C": r.key = KEY_RIGHT;
				"D": r.key = KEY_LEFT;
				"H": r.key = KEY_HOME;
				"F": r.key = KEY_END;
				default: ;
			endcase
			if (c3 == CHAR_TILDE || c3 == CHAR_SEMI) begin
				case (c2)
					"2": r.key = KEY_INS;
					"3": r.key = KEY_DEL;
					"5": r.key = KEY_PGUP;
					"6": r.key = KEY_PGDN;
					default: ;
				endcase
			end
		end else if (c1 == CHAR_SS3) begin
			case (c2)
				"P": r.key = KEY_F1;
				"Q": r.key = KEY_F2;
				"R": r.key = KEY_F3;
				"S": r.key = KEY_F4;
				default: ;
			endcase
		end else begin
			r.key = KEY_CHAR;
			r.ch = c1;
			r.al = 1'b1;
		end
		return r;
	endfunction

	function automatic void predict_byte(input logic [7:0] b, input logic last);
		if (!halted) begin
			live_items++;
			if (b == CHAR_ESC || b == CHAR_NUL) begin
				halted = 1'b1;
			end else begin
				if (kept < HEAD_LEN) begin
					head_q[kept] = b;
					kept++;
				end
				mouse_parse(b);
			end
		end
		if (last) begin
			expected_reports.push_back(decode_report());
			sequences++;
			clear_decoder();
		end
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40) $display("mismatch @%0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [12:0] got,
			input logic [12:0] want);
		if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	task automatic send_item(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		seq_byte <= b;
		seq_end <= last;
		do @(posedge clk); while (!in_ready);
		predict_byte(b, last);
	endtask

	task automatic send_sequence();
		int n;
		n = seq_bytes.size();
		for (int i = 0; i < n; i++) send_item(seq_bytes[i], i == n - 1);
		seq_bytes.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) seq_bytes.push_back(s[i]);
	endtask

	task automatic add_num(input int unsigned v);
		add_text($sformatf("%0d", v));
	endtask

	function automatic int unsigned rand_coord();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0) return 0;
		if (r == 1) return $urandom_range(4000, 99999);
		return $urandom_range(1, 300);
	endfunction

	// mostly well-formed keys and mouse reports, some broken, some plain noise
	task automatic rand_sequence();
		string letters, interesting;
		int unsigned tilde_codes [12];
		int unsigned mouse_types [10];
		int unsigned pick, mod, t, drop;
		bit shaped;
		letters = "ABCDHF";
		interesting = "[<;0123456789~OMmABCDHFPQRS";
		tilde_codes = '{2, 3, 5, 6, 15, 17, 18, 19, 20, 21, 23, 24};
		mouse_types = '{0, 1, 2, 3, 32, 33, 34, 35, 64, 65};
		pick = $urandom_range(0, 99);
		shaped = 1'b1;
		mod = $urandom_range(0, 9);
		if (pick < 30) begin
			if ($urandom_range(0, 1)) begin
				if (mod >= 2) begin
					add_text("[1;");
					add_num(mod);
				end else begin
					add_text("[");
				end
				seq_bytes.push_back(letters[$urandom_range(0, 5)]);
			end else begin
				add_text("[");
				add_num(tilde_codes[$urandom_range(0, 11)]);
				if (mod >= 2) begin
					add_text(";");
					add_num(mod);
				end
				add_text("~");
			end
		end else if (pick < 40) begin
			add_text("O");
			if ($urandom_range(0, 4) == 0) seq_bytes.push_back(8'($urandom_range(0, 255)));
			else seq_bytes.push_back(interesting[$urandom_range(23, 26)]);
		end else if (pick < 70) begin
			t = $urandom_range(0, 19);
			if (t == 0) t = $urandom_range(4000, 99999);
			else if (t < 4) t = $urandom_range(0, 200);
			else t = mouse_types[$urandom_range(0, 9)] + 8 * $urandom_range(0, 3);
			add_text("[<");
			add_num(t);
			add_text(";");
			add_num(rand_coord());
			add_text(";");
			add_num(rand_coord());
			add_text($urandom_range(0, 1) ? "M" : "m");
			if ($urandom_range(0, 9) == 0) begin
				drop = $urandom_range(1, seq_bytes.size() - 1);
				repeat (drop) void'(seq_bytes.pop_back());
			end
		end else if (pick < 80) begin
			seq_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			shaped = 1'b0;
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 19) == 0)
					seq_bytes.push_back($urandom_range(0, 1) ? CHAR_ESC : CHAR_NUL);
				else if ($urandom_range(0, 1))
					seq_bytes.push_back(8'($urandom_range(0, 255)));
				else
					seq_bytes.push_back(interesting[$urandom_range(0, interesting.len() - 1)]);
			end
		end
		if (shaped && $urandom_range(0, 9) == 0)
			seq_bytes[$urandom_range(0, seq_bytes.size() - 1)] = 8'($urandom_range(0, 255));
		// a stray terminator, then bytes the decoder must ignore
		if ($urandom_range(0, 19) == 0) begin
			seq_bytes.push_back(CHAR_ESC);
			repeat ($urandom_range(0, 3)) seq_bytes.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_keys();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// empty sequence, then a terminator with ignored bytes behind it
		seq_bytes.push_back(CHAR_ESC);
		send_sequence();
		add_text("a");
		seq_bytes.push_back(CHAR_ESC);
		add_text("z");
		send_sequence();
		seq_bytes.push_back(8'hFF);
		send_sequence();
		add_text("[1;8A");
		send_sequence();
		add_text("[24;2~");
		send_sequence();
		add_text("OS");
		send_sequence();
	endtask

	task automatic test_mouse();
		// wheel up with alt and ctrl bits, row number zero
		add_text("[<88;1;0m");
		send_sequence();
		// a sign before the type stops the scan
		add_text("[<+5M");
		send_sequence();
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct, input int n_items);
		int start;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		start = live_items;
		while (live_items - start < n_items) begin
			rand_sequence();
			send_sequence();
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_len = 60;
		hold_requests++;
		// short sequences pile up results while the receiver holds off
		repeat (25) begin
			seq_bytes.push_back(8'($urandom_range(1, 255)));
			send_sequence();
		end
		repeat (10) begin
			rand_sequence();
			send_sequence();
		end
	endtask

	// receiver side: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_left = hold_len;
			hold_served++;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_ready) input_stalls++;
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					report_mismatch("result with no sequence outstanding");
				end else begin
					head_report = expected_reports.pop_front();
					check_field("key_code", key_code, head_report.key);
					check_field("key_char", key_char, head_report.ch);
					check_field("shift_mod", shift_mod, head_report.sh);
					check_field("ctrl_mod", ctrl_mod, head_report.ct);
					check_field("alt_mod", alt_mod, head_report.al);
					check_field("mouse_valid", mouse_valid, head_report.mv);
					check_field("mouse_pressed", mouse_pressed, head_report.mp);
					check_field("mouse_event", mouse_event, head_report.ev);
					check_field("mouse_col", mouse_col, head_report.col);
					check_field("mouse_row", mouse_row, head_report.row);
					if (head_report.mv) mouse_seen++;
					if (head_report.key != KEY_NONE) keys_seen++;
				end
			end
		end
	end

	initial begin
		#400000;
		$display("terminal_escape_input_decoder_unit regression: fail");
		$finish;
	end

	initial begin
		int waited;
		clear_decoder();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_keys();
		test_mouse();
		test_random(0, 0, 80);
		test_random(71, 0, 80);
		test_random(0, 71, 80);
		test_random(34, 34, 80);
		test_backpressure();
		in_valid <= 1'b0;
		waited = 0;
		while (expected_reports.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (expected_reports.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_reports.size()));
		$display("covered %0d sequences over %0d live items: %0d mouse reports, %0d keys",
			sequences, live_items, mouse_seen, keys_seen);
		$display("input held off by a full decoder for %0d cycles", input_stalls);
		if (errors == 0) begin
			$display("terminal_escape_input_decoder_unit regression: pass");
		end else begin
			$display("terminal_escape_input_decoder_unit regression: fail");
		end
		$finish;
	end

endmodule
